// ===== rtl/pma_pkg.sv =====
package pma_pkg;

  localparam int PIX_W     = 32;
  localparam int CH_W      = 8;
  localparam int N_CH      = 3;
  localparam int ALPHA_LSB = 24;
  localparam int PROD_W    = 2 * CH_W;
  localparam int NUM_W     = PROD_W + 1;
  localparam int DIV_W     = CH_W + 1;
  localparam int QUO_W     = CH_W;
  localparam int QPOS_W    = $clog2(QUO_W);
  localparam int DIV_STEP  = 2;
  localparam int DIV_STG   = QUO_W / DIV_STEP;
  localparam int N_STG     = DIV_STG + 1;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [DIV_W-1:0] dvsr_t;
  typedef logic [QUO_W-1:0] quo_t;
  typedef logic [CH_W-1:0]  chan_t;

  typedef struct packed {
    num_t rem;
    logic q;
  } div_step_t;

  // One restoring step: try to take the shifted divisor out of the remainder.
  function automatic div_step_t pma_div_step(input num_t rem, input dvsr_t d,
                                             input logic [QPOS_W-1:0] pos);
    num_t      dsh;
    div_step_t res;
    dsh = NUM_W'(d) << pos;
    if (rem >= dsh) begin
      res.rem = rem - dsh;
      res.q   = 1'b1;
    end else begin
      res.rem = rem;
      res.q   = 1'b0;
    end
    return res;
  endfunction

endpackage

// ===== rtl/pma_pair.sv =====
module pma_pair
  import pma_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_p,
  input  logic [PIX_W-1:0] in_q,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_pixel
);

  // Stage 0 holds the weighted sums, stages 1..DIV_STG retire quotient bits.
  logic  v_r    [N_STG];
  num_t  rem_r  [N_STG][N_CH];
  quo_t  quo_r  [N_STG][N_CH];
  dvsr_t dvsr_r [N_STG];
  chan_t alpha_r[N_STG];

  num_t  rem_nxt  [N_STG][N_CH];
  quo_t  quo_nxt  [N_STG][N_CH];
  dvsr_t dvsr_nxt [N_STG];
  chan_t alpha_nxt[N_STG];
  logic  en       [N_STG+1];

  always_comb begin
    en[N_STG] = out_ready;
    for (int k = N_STG - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_comb begin
    chan_t             ap, aq;
    logic [DIV_W-1:0]  asum;
    logic [PROD_W-1:0] prod_p, prod_q;
    num_t              r;
    quo_t              q;
    div_step_t         st;
    // Weighted sums c_p*a_p + c_q*a_q and the forced-nonzero divisor.
    ap   = in_p[ALPHA_LSB +: CH_W];
    aq   = in_q[ALPHA_LSB +: CH_W];
    asum = {1'b0, ap} + {1'b0, aq};
    alpha_nxt[0] = asum[DIV_W-1:1];
    dvsr_nxt[0]  = (asum == '0) ? DIV_W'(1) : asum;
    for (int ch = 0; ch < N_CH; ch++) begin
      prod_p = in_p[ch*CH_W +: CH_W] * ap;
      prod_q = in_q[ch*CH_W +: CH_W] * aq;
      rem_nxt[0][ch] = {1'b0, prod_p} + {1'b0, prod_q};
      quo_nxt[0][ch] = '0;
    end
    // Quotient is known to fit in a channel, so start at the top channel bit.
    for (int k = 1; k < N_STG; k++) begin
      alpha_nxt[k] = alpha_r[k-1];
      dvsr_nxt[k]  = dvsr_r[k-1];
      for (int ch = 0; ch < N_CH; ch++) begin
        r = rem_r[k-1][ch];
        q = quo_r[k-1][ch];
        for (int j = 0; j < DIV_STEP; j++) begin
          st = pma_div_step(r, dvsr_r[k-1], QPOS_W'(QUO_W - 1 - (k - 1) * DIV_STEP - j));
          r  = st.rem;
          q  = {q[QUO_W-2:0], st.q};
        end
        rem_nxt[k][ch] = r;
        quo_nxt[k][ch] = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N_STG; k++) v_r[k] <= 1'b0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < N_STG; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N_STG; k++) begin
      if (en[k]) begin
        alpha_r[k] <= alpha_nxt[k];
        dvsr_r[k]  <= dvsr_nxt[k];
        for (int ch = 0; ch < N_CH; ch++) begin
          rem_r[k][ch] <= rem_nxt[k][ch];
          quo_r[k][ch] <= quo_nxt[k][ch];
        end
      end
    end
  end

  assign out_valid = v_r[N_STG-1];

  always_comb begin
    out_pixel = '0;
    out_pixel[ALPHA_LSB +: CH_W] = alpha_r[N_STG-1];
    for (int ch = 0; ch < N_CH; ch++) begin
      out_pixel[ch*CH_W +: CH_W] = quo_r[N_STG-1][ch];
    end
  end

endmodule

// ===== rtl/premultiplied_alpha_mipmap_downsample.sv =====
// Premultiplied-alpha 2x2 box downsample: one ARGB8888 quad in, one mip pixel
// out. Throughput is one quad per clock while the output is not stalled. Each
// pair average runs through a five-stage unit (one stage forms the
// alpha-weighted sums, four stages of a restoring divider retire two quotient
// bits each), and two such levels are chained: the top and bottom pairs in
// parallel, then their results. Stalls back up stage by stage, so bubbles are
// squeezed out and a new quad is taken whenever any stage is free.
module premultiplied_alpha_mipmap_downsample
  import pma_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] in_top_left,
  input  logic [PIX_W-1:0] in_top_right,
  input  logic [PIX_W-1:0] in_bottom_left,
  input  logic [PIX_W-1:0] in_bottom_right,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_pixel
);

  logic             top_ready, bot_ready, top_valid, bot_valid;
  logic             mix_ready;
  logic [PIX_W-1:0] top_pixel, bot_pixel;

  pma_pair u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (top_ready),
    .in_p      (in_top_left),
    .in_q      (in_top_right),
    .out_valid (top_valid),
    .out_ready (mix_ready),
    .out_pixel (top_pixel)
  );

  pma_pair u_bot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (bot_ready),
    .in_p      (in_bottom_left),
    .in_q      (in_bottom_right),
    .out_valid (bot_valid),
    .out_ready (mix_ready),
    .out_pixel (bot_pixel)
  );

  pma_pair u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (top_valid && bot_valid),
    .in_ready  (mix_ready),
    .in_p      (top_pixel),
    .in_q      (bot_pixel),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_pixel (out_pixel)
  );

  assign in_stall = !(top_ready && bot_ready);

  // Row units run in lockstep.
  a_row_valid_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    top_valid == bot_valid)
    else $error("row pair units lost lockstep on valid");

  a_row_ready_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    top_ready == bot_ready)
    else $error("row pair units lost lockstep on ready");

  // An open output lets every stage advance, so the input must be open too.
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && in_valid && !in_stall |=> out_valid)
    else $error("pending result dropped while taking a new quad");

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pma_pkg::PIX_W;

  typedef logic [PIX_W-1:0] argb_t;

  // Directed row: the expected pixel is typed in only where it is obvious.
  typedef struct packed {
    argb_t tl;
    argb_t tr;
    argb_t bl;
    argb_t br;
    logic  known;
    argb_t pixel;
  } quad_row_t;

  localparam int N_DIR = 14;

  localparam quad_row_t DIR_ROWS [N_DIR] = '{
    '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
    '{32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 1'b1, 32'h00000000},
    '{32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000, 1'b1, 32'hFF000000},
    '{32'hFFFFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 1'b1, 32'h3FFFFFFF},
    '{32'h00000000, 32'h00000000, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h3FFFFFFF},
    '{32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA, 1'b1, 32'hAAAAAAAA},
    '{32'h55555555, 32'h55555555, 32'h55555555, 32'h55555555, 1'b1, 32'h55555555},
    '{32'h01010101, 32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000},
    '{32'hFF0000FF, 32'hFF00FF00, 32'hFFFF0000, 32'hFFFFFFFF, 1'b0, 32'h00000000},
    '{32'h01FFFFFF, 32'hFF000000, 32'h01FFFFFF, 32'hFF000000, 1'b0, 32'h00000000},
    '{32'h80FF0000, 32'h7F00FF00, 32'h01000001, 32'hFE0000FE, 1'b0, 32'h00000000},
    '{32'h01FFFFFF, 32'h02000000, 32'h03123456, 32'h00ABCDEF, 1'b0, 32'h00000000},
    '{32'hFFFFFFFF, 32'h00000000, 32'h00000000, 32'hFFFFFFFF, 1'b0, 32'h00000000}
  };

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  argb_t in_top_left = '0;
  argb_t in_top_right = '0;
  argb_t in_bottom_left = '0;
  argb_t in_bottom_right = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  argb_t out_pixel;

  argb_t mip_pixel_q [$];
  int    err_cnt = 0;
  int    quad_cnt = 0;
  int    pixel_cnt = 0;
  int    send_gap_pct = 0;
  int    recv_stall_pct = 0;
  int    hold_req_cnt = 0;
  int    hold_seen_cnt = 0;
  int    hold_left = 0;

  premultiplied_alpha_mipmap_downsample dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_top_left     (in_top_left),
    .in_top_right    (in_top_right),
    .in_bottom_left  (in_bottom_left),
    .in_bottom_right (in_bottom_right),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel       (out_pixel)
  );

  always #10 clk = ~clk;

  // Alpha-weighted average of two ARGB pixels.
  function automatic argb_t blend_pair(input argb_t p, input argb_t q);
    logic [8:0]  asum;
    logic [8:0]  dvsr;
    logic [16:0] num;
    logic [16:0] quo;
    argb_t       res;
    int          ch;
    asum = {1'b0, p[31:24]} + {1'b0, q[31:24]};
    dvsr = (asum == 9'd0) ? 9'd1 : asum;
    res = '0;
    res[31:24] = asum[8:1];
    for (ch = 0; ch < 3; ch++) begin
      num = 17'(p[ch*8 +: 8]) * 17'(p[31:24]) + 17'(q[ch*8 +: 8]) * 17'(q[31:24]);
      quo = num / 17'(dvsr);
      res[ch*8 +: 8] = quo[7:0];
    end
    return res;
  endfunction

  function automatic argb_t quad_downsample(input argb_t tl, input argb_t tr,
                                            input argb_t bl, input argb_t br);
    return blend_pair(blend_pair(tl, tr), blend_pair(bl, br));
  endfunction

  // Bias alpha toward its edge values; color bits stay fully random.
  function automatic argb_t rand_argb();
    logic [7:0] a;
    case ($urandom_range(9))
      0: a = 8'h00;
      1: a = 8'hFF;
      2: a = 8'h01;
      3: a = 8'hFE;
      default: a = 8'($urandom);
    endcase
    return {a, 24'($urandom)};
  endfunction

  task automatic send_quad(input argb_t tl, input argb_t tr, input argb_t bl,
                           input argb_t br, input argb_t pix_exp);
    // Insert idle cycles while a draw falls below the requested gap probability.
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_top_left     <= tl;
    in_top_right    <= tr;
    in_bottom_left  <= bl;
    in_bottom_right <= br;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mip_pixel_q.push_back(pix_exp);
    quad_cnt++;
  endtask

  task automatic send_random(input int n);
    argb_t px [4];
    int    k;
    int    i;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: begin
          px[0] = rand_argb();
          for (k = 1; k < 4; k++) px[k] = px[0];
        end
        1: for (k = 0; k < 4; k++) px[k] = {8'h00, 24'($urandom)};
        default: for (k = 0; k < 4; k++) px[k] = rand_argb();
      endcase
      send_quad(px[0], px[1], px[2], px[3], quad_downsample(px[0], px[1], px[2], px[3]));
    end
  endtask

  task automatic wait_drained();
    while (mip_pixel_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req_cnt != hold_seen_cnt) begin
      hold_seen_cnt = hold_req_cnt;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (mip_pixel_q.size() == 0) begin
        $display("%0t: unexpected out_pixel transaction: expected none, actual %08h",
                 $time, out_pixel);
        err_cnt++;
      end else begin
        if (out_pixel !== mip_pixel_q[0]) begin
          $display("%0t: out_pixel mismatch: expected %08h, actual %08h",
                   $time, mip_pixel_q[0], out_pixel);
          err_cnt++;
        end
        void'(mip_pixel_q.pop_front());
        pixel_cnt++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d pixels outstanding", mip_pixel_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    argb_t pix_exp;
    int    i;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    send_gap_pct   = 25;
    recv_stall_pct = 45;
    for (i = 0; i < N_DIR; i++) begin
      pix_exp = DIR_ROWS[i].known ? DIR_ROWS[i].pixel :
                quad_downsample(DIR_ROWS[i].tl, DIR_ROWS[i].tr,
                                DIR_ROWS[i].bl, DIR_ROWS[i].br);
      send_quad(DIR_ROWS[i].tl, DIR_ROWS[i].tr, DIR_ROWS[i].bl, DIR_ROWS[i].br, pix_exp);
    end
    send_random(200);

    send_gap_pct   = 45;
    recv_stall_pct = 25;
    send_random(100);

    // Hold the output long enough for the pipe to fill and back up the input.
    send_gap_pct = 0;
    hold_req_cnt++;
    send_random(40);

    // Pause the input until the pipe is empty.
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    send_gap_pct = 45;
    send_random(100);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_random(250);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d quads, checked %0d pixels: edge alphas, zero-alpha pairs,",
             quad_cnt, pixel_cnt);
    $display("uniform quads, random ARGB under mixed stalls and a full-pipe hold-off");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
